@@ src/dpbc_pkg.sv @@
// Shared constants and saturation helpers for the dual PID balance controller.
package dpbc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ERROR_W  = 17;
    localparam int GAIN_W   = 32;
    localparam int TERM_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_PEND_SP = 3'd0;
    localparam logic [2:0] REG_CART_SP = 3'd1;
    localparam logic [2:0] REG_PEND_KP = 3'd2;
    localparam logic [2:0] REG_PEND_KI = 3'd3;
    localparam logic [2:0] REG_PEND_KD = 3'd4;
    localparam logic [2:0] REG_CART_KP = 3'd5;
    localparam logic [2:0] REG_CART_KI = 3'd6;
    localparam logic [2:0] REG_CART_KD = 3'd7;

    localparam logic signed [15:0] PEND_SP_RESET = 16'sd0;
    localparam logic signed [15:0] CART_SP_RESET = 16'sd0;
    localparam logic signed [31:0] PEND_KP_RESET = 32'sd335544320;
    localparam logic signed [31:0] PEND_KI_RESET = 32'sd2348810;
    localparam logic signed [31:0] PEND_KD_RESET = 32'sd167772160;
    localparam logic signed [31:0] CART_KP_RESET = -32'sd3355443;
    localparam logic signed [31:0] CART_KI_RESET = -32'sd3355;
    localparam logic signed [31:0] CART_KD_RESET = -32'sd838861;

    // Fifteen degrees in Q8.8.
    localparam logic signed [16:0] SWING_LIMIT = 17'sd3840;

    localparam logic signed [31:0] I32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat_from33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? I32_MIN : I32_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_from48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7fff_ffff) begin
            r = I32_MAX;
        end else if (v < -48'sh0000_8000_0000) begin
            r = I32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/dual_pid_balance_controller.sv @@
// Top level of the dual PID balance controller: config registers and three-stage datapath.
//
// Each input beat carries a pendulum angle and a cart position (signed Q8.8). The block
// forms both errors against the setpoints and, unless the pendulum error exceeds fifteen
// degrees, advances the two PID loops and returns both terms and their saturated sum as
// Q16.16 drive. In swing-up it flags the beat, reports the errors, gives zero drive and
// leaves the integrals and previous errors untouched.
// The input register is loaded at the accepting edge; the beat then passes the multiplier
// register and the result register, which drives m_valid. One beat is taken per cycle
// while m_ready is high. Loop state advances when a beat leaves the input register.
// When m_ready is low the stages fill up and s_ready drops once all three hold a beat;
// nothing is lost or repeated. Reset (aresetn low, synchronous) empties the pipeline,
// clears the loop state and restores the default setpoints and gains. Gains and setpoints are
// written over APB at byte address 4*index; the user must write only while idle (not enforced).
module dual_pid_balance_controller (
    input  logic                aclk,
    input  logic                aresetn,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Sample input
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_pend_angle,
    input  logic signed [15:0]  s_cart_position,
    // Result output
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_drive,
    output logic signed [16:0]  m_pend_error,
    output logic signed [16:0]  m_cart_error,
    output logic signed [31:0]  m_pend_term,
    output logic signed [31:0]  m_cart_term,
    output logic                m_swing_up
);

    // Configuration registers
    logic signed [15:0] pend_sp_reg, cart_sp_reg;
    logic signed [31:0] pend_kp_reg, pend_ki_reg, pend_kd_reg;
    logic signed [31:0] cart_kp_reg, cart_ki_reg, cart_kd_reg;
    logic [2:0]         reg_index;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_sp_reg <= dpbc_pkg::PEND_SP_RESET;
            cart_sp_reg <= dpbc_pkg::CART_SP_RESET;
            pend_kp_reg <= dpbc_pkg::PEND_KP_RESET;
            pend_ki_reg <= dpbc_pkg::PEND_KI_RESET;
            pend_kd_reg <= dpbc_pkg::PEND_KD_RESET;
            cart_kp_reg <= dpbc_pkg::CART_KP_RESET;
            cart_ki_reg <= dpbc_pkg::CART_KI_RESET;
            cart_kd_reg <= dpbc_pkg::CART_KD_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                dpbc_pkg::REG_PEND_SP: pend_sp_reg <= pwdata[15:0];
                dpbc_pkg::REG_CART_SP: cart_sp_reg <= pwdata[15:0];
                dpbc_pkg::REG_PEND_KP: pend_kp_reg <= pwdata;
                dpbc_pkg::REG_PEND_KI: pend_ki_reg <= pwdata;
                dpbc_pkg::REG_PEND_KD: pend_kd_reg <= pwdata;
                dpbc_pkg::REG_CART_KP: cart_kp_reg <= pwdata;
                dpbc_pkg::REG_CART_KI: cart_ki_reg <= pwdata;
                dpbc_pkg::REG_CART_KD: cart_kd_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            dpbc_pkg::REG_PEND_SP: prdata = {{16{pend_sp_reg[15]}}, pend_sp_reg};
            dpbc_pkg::REG_CART_SP: prdata = {{16{cart_sp_reg[15]}}, cart_sp_reg};
            dpbc_pkg::REG_PEND_KP: prdata = pend_kp_reg;
            dpbc_pkg::REG_PEND_KI: prdata = pend_ki_reg;
            dpbc_pkg::REG_PEND_KD: prdata = pend_kd_reg;
            dpbc_pkg::REG_CART_KP: prdata = cart_kp_reg;
            dpbc_pkg::REG_CART_KI: prdata = cart_ki_reg;
            dpbc_pkg::REG_CART_KD: prdata = cart_kd_reg;
            default:               prdata = '0;
        endcase
    end

    // Pipeline control
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2;

    assign adv2    = v2_reg && (!v3_reg || m_ready);
    assign adv1    = v1_reg && (!v2_reg || adv2);
    assign s_ready = !v1_reg || adv1;
    assign m_valid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                v1_reg <= s_valid;
            end
            if (!v2_reg || adv2) begin
                v2_reg <= v1_reg;
            end
            if (!v3_reg || m_ready) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: input register
    logic signed [15:0] angle1_reg, position1_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            angle1_reg    <= s_pend_angle;
            position1_reg <= s_cart_position;
        end
    end

    // Errors, loop state update and products
    logic signed [16:0] pend_dev, cart_dev;
    logic               swing1;
    logic signed [31:0] pend_integral_reg, cart_integral_reg;
    logic signed [16:0] pend_last_reg, cart_last_reg;
    logic signed [31:0] pend_integral_next, cart_integral_next;
    logic signed [17:0] pend_diff, cart_diff;
    logic signed [48:0] pend_p_prod, cart_p_prod;
    logic signed [63:0] pend_i_prod, cart_i_prod;
    logic signed [49:0] pend_d_prod, cart_d_prod;

    always_comb begin
        pend_dev = 17'(pend_sp_reg) - 17'(angle1_reg);
        cart_dev = 17'(cart_sp_reg) - 17'(position1_reg);
        swing1   = (pend_dev > dpbc_pkg::SWING_LIMIT) || (pend_dev < -dpbc_pkg::SWING_LIMIT);

        pend_integral_next = dpbc_pkg::sat_from33(33'(pend_integral_reg) + 33'(pend_dev));
        cart_integral_next = dpbc_pkg::sat_from33(33'(cart_integral_reg) + 33'(cart_dev));
        pend_diff = 18'(pend_dev) - 18'(pend_last_reg);
        cart_diff = 18'(cart_dev) - 18'(cart_last_reg);

        pend_p_prod = 49'(pend_kp_reg) * 49'(pend_dev);
        cart_p_prod = 49'(cart_kp_reg) * 49'(cart_dev);
        pend_i_prod = 64'(pend_ki_reg) * 64'(pend_integral_next);
        cart_i_prod = 64'(cart_ki_reg) * 64'(cart_integral_next);
        pend_d_prod = 50'(pend_kd_reg) * 50'(pend_diff);
        cart_d_prod = 50'(cart_kd_reg) * 50'(cart_diff);
    end

    // The loops advance only on beats that run the PIDs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_integral_reg <= '0;
            cart_integral_reg <= '0;
            pend_last_reg     <= '0;
            cart_last_reg     <= '0;
        end else if (adv1 && !swing1) begin
            pend_integral_reg <= pend_integral_next;
            cart_integral_reg <= cart_integral_next;
            pend_last_reg     <= pend_dev;
            cart_last_reg     <= cart_dev;
        end
    end

    // Stage 2: product register
    logic signed [48:0] pend_p2_reg, cart_p2_reg;
    logic signed [63:0] pend_i2_reg, cart_i2_reg;
    logic signed [49:0] pend_d2_reg, cart_d2_reg;
    logic signed [16:0] pend_dev2_reg, cart_dev2_reg;
    logic               swing2_reg;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            pend_p2_reg   <= pend_p_prod;
            cart_p2_reg   <= cart_p_prod;
            pend_i2_reg   <= pend_i_prod;
            cart_i2_reg   <= cart_i_prod;
            pend_d2_reg   <= pend_d_prod;
            cart_d2_reg   <= cart_d_prod;
            pend_dev2_reg <= pend_dev;
            cart_dev2_reg <= cart_dev;
            swing2_reg    <= swing1;
        end
    end

    // Sums carry 32 fractional bits; taking bits 63:16 floors them to Q16.16.
    logic signed [63:0] pend_sum, cart_sum;
    logic signed [31:0] pend_term, cart_term, drive;

    always_comb begin
        pend_sum = 64'(pend_p2_reg) + pend_i2_reg + 64'(pend_d2_reg);
        cart_sum = 64'(cart_p2_reg) + cart_i2_reg + 64'(cart_d2_reg);
        if (swing2_reg) begin
            pend_term = '0;
            cart_term = '0;
        end else begin
            pend_term = dpbc_pkg::sat_from48(pend_sum[63:16]);
            cart_term = dpbc_pkg::sat_from48(cart_sum[63:16]);
        end
        drive = dpbc_pkg::sat_from33(33'(pend_term) + 33'(cart_term));
    end

    // Stage 3: result register
    logic signed [31:0] drive_reg, pend_term_reg, cart_term_reg;
    logic signed [16:0] pend_error_reg, cart_error_reg;
    logic               swing_up_reg;

    always_ff @(posedge aclk) begin
        if (adv2) begin
            drive_reg      <= drive;
            pend_term_reg  <= pend_term;
            cart_term_reg  <= cart_term;
            pend_error_reg <= pend_dev2_reg;
            cart_error_reg <= cart_dev2_reg;
            swing_up_reg   <= swing2_reg;
        end
    end

    assign m_drive      = drive_reg;
    assign m_pend_term  = pend_term_reg;
    assign m_cart_term  = cart_term_reg;
    assign m_pend_error = pend_error_reg;
    assign m_cart_error = cart_error_reg;
    assign m_swing_up   = swing_up_reg;

    // Checks
    a_swing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_swing_up |-> m_drive == 0 && m_pend_term == 0 && m_cart_term == 0)
        else $error("swing-up beat carries a nonzero drive or term");

    a_swing_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_swing_up |->
            m_pend_error > dpbc_pkg::SWING_LIMIT || m_pend_error < -dpbc_pkg::SWING_LIMIT)
        else $error("swing-up flagged within the balance window");

    a_swing_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        adv1 && swing1 |=> $stable(pend_integral_reg) && $stable(cart_integral_reg)
            && $stable(pend_last_reg) && $stable(cart_last_reg))
        else $error("loop state changed on a swing-up beat");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

endmodule
